FILE: hdl/csf_pkg.sv
// ----------------------------------------------------------------------------
// csf_pkg
// Shared types, constants and the digit pattern table for the clock and
// stopwatch segment formatter.
// ----------------------------------------------------------------------------
package csf_pkg;

  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [31:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] segments_d3;
    logic [7:0] segments_d2;
    logic [7:0] segments_d1;
    logic [7:0] segments_d0;
    logic [3:0] blink_mask;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_CLOCK     = 2'd0,
    MODE_SETTING   = 2'd1,
    MODE_STOPWATCH = 2'd2,
    MODE_OTHER     = 2'd3
  } mode_t;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_MODE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EDIT_FIELD   = 8'd1;

  localparam logic [3:0] BLINK_NONE    = 4'h0;
  localparam logic [3:0] BLINK_HOURS   = 4'hC;
  localparam logic [3:0] BLINK_MINUTES = 4'h3;

  localparam logic [7:0] SEG_DP = 8'h80;

  // Reciprocals for exact division by constants.
  // ms / 1000 = (ms >> 3) / 125 : multiply by ceil(2^36 / 125), keep bits above 36.
  localparam logic [29:0] MS_DIV_MUL    = 30'd549755814;
  // s / 60 = (s >> 2) / 15 : multiply by ceil(2^28 / 15), keep bits above 28.
  localparam logic [24:0] SEC_DIV_MUL   = 25'd17895698;
  // m / 100 = (m >> 2) / 25 : multiply by ceil(2^20 / 25), keep bits above 20.
  localparam logic [15:0] HUND_DIV_MUL  = 16'd41944;

  // Stage side data that travels with each item next to the arithmetic.
  typedef struct packed {
    logic       stopwatch;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [3:0] blink;
  } side_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] seg;
    case (d)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

FILE: hdl/csf_seg_pair.sv
// ----------------------------------------------------------------------------
// csf_seg_pair
// Splits a value of 0 to 99 into tens and units and encodes both digits as
// seven-segment codes.
// ----------------------------------------------------------------------------
module csf_seg_pair
  import csf_pkg::*;
(
  input  logic [6:0] value,
  output logic [7:0] seg_tens,
  output logic [7:0] seg_units
);

  logic [3:0] tens;
  logic [6:0] units_full;

  always_comb begin
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (value >= 7'(10 * k)) begin
        tens = 4'(k);
      end
    end
  end

  // tens * 10 as a shift and add.
  assign units_full = value - {tens, 3'b000} - {2'b00, tens, 1'b0};

  assign seg_tens  = digit_seg(tens);
  assign seg_units = digit_seg(units_full[3:0]);

endmodule

FILE: hdl/clock_stopwatch_segment_formatter_core.sv
// ----------------------------------------------------------------------------
// clock_stopwatch_segment_formatter_core
// Formats hours and minutes, or a stopwatch millisecond count, as four
// seven-segment digit codes with a blink mask.
// ----------------------------------------------------------------------------
// The pipeline takes one item per cycle unless out_ready holds the output beat.
// The three reciprocal multiplies (by 1/1000, 1/60 and 1/100) set the depth,
// one multiplier per stage, then a stage for remainders and one for encoding.
// Reset (synchronous, rst_n low) empties the pipeline and sets display_mode
// and edit_field to zero. Items in mode other are taken and dropped.
module clock_stopwatch_segment_formatter_core
  import csf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  mode_t mode_r;
  logic  edit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CLOCK;
      edit_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DISPLAY_MODE: mode_r <= mode_t'(cfg_data[1:0]);
        REG_EDIT_FIELD:   edit_r <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Stage valids and per-stage ready chain.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  logic in_fire;
  logic in_keep;
  assign in_fire = in_valid && in_ready;
  assign in_keep = (mode_r != MODE_OTHER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_fire && in_keep;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // Stage 1: seconds = ms / 1000.
  side_t       side_nxt;
  side_t       side1_r, side2_r, side3_r, side4_r;
  logic [58:0] p1;
  logic [22:0] sec1_r;

  always_comb begin
    side_nxt.stopwatch = (mode_r == MODE_STOPWATCH);
    side_nxt.hours     = in_data.hours;
    side_nxt.minutes   = in_data.minutes;
    if (mode_r == MODE_SETTING) begin
      side_nxt.blink = edit_r ? BLINK_MINUTES : BLINK_HOURS;
    end else begin
      side_nxt.blink = BLINK_NONE;
    end
  end

  assign p1 = 59'(in_data.elapsed_ms[31:3]) * 59'(MS_DIV_MUL);

  always_ff @(posedge clk) begin
    if (rdy1) begin
      side1_r <= side_nxt;
      sec1_r  <= p1[58:36];
    end
  end

  // Stage 2: whole minutes = seconds / 60.
  logic [45:0] p2;
  logic [16:0] min2_r;
  logic [22:0] sec2_r;

  assign p2 = 46'(sec1_r[22:2]) * 46'(SEC_DIV_MUL);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      side2_r <= side1_r;
      sec2_r  <= sec1_r;
      min2_r  <= p2[44:28];
    end
  end

  // Stage 3: seconds remainder, and hundreds of minutes.
  logic [30:0] p3;
  logic [22:0] sec_rem;
  logic [9:0]  hund3_r;
  logic [16:0] min3_r;
  logic [5:0]  ss3_r;

  assign p3      = 31'(min2_r[16:2]) * 31'(HUND_DIV_MUL);
  assign sec_rem = sec2_r - ({min2_r, 6'b0} - {4'b0, min2_r, 2'b0});

  always_ff @(posedge clk) begin
    if (rdy3) begin
      side3_r <= side2_r;
      min3_r  <= min2_r;
      hund3_r <= p3[29:20];
      ss3_r   <= sec_rem[5:0];
    end
  end

  // Stage 4: minutes mod 100, then pick the digit pairs for the mode.
  logic [16:0] hund_x100;
  logic [16:0] mm_full;
  logic [6:0]  left_nxt;
  logic [6:0]  left4_r;
  logic [6:0]  right_nxt;
  logic [6:0]  right4_r;

  assign hund_x100 = 17'({hund3_r, 6'b0}) + 17'({hund3_r, 5'b0}) + 17'({hund3_r, 2'b0});
  assign mm_full   = min3_r - hund_x100;

  always_comb begin
    if (side3_r.stopwatch) begin
      left_nxt  = mm_full[6:0];
      right_nxt = {1'b0, ss3_r};
    end else begin
      left_nxt  = {2'b00, side3_r.hours};
      right_nxt = {1'b0, side3_r.minutes};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      side4_r  <= side3_r;
      left4_r  <= left_nxt;
      right4_r <= right_nxt;
    end
  end

  // Stage 5: digit split and segment encoding into the output register.
  logic [7:0] seg_lt, seg_lu, seg_rt, seg_ru;
  out_item_t  out_r;

  csf_seg_pair u_left (
    .value     (left4_r),
    .seg_tens  (seg_lt),
    .seg_units (seg_lu)
  );

  csf_seg_pair u_right (
    .value     (right4_r),
    .seg_tens  (seg_rt),
    .seg_units (seg_ru)
  );

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_r.segments_d3 <= seg_lt;
      out_r.segments_d2 <= seg_lu | SEG_DP;
      out_r.segments_d1 <= seg_rt;
      out_r.segments_d0 <= seg_ru;
      out_r.blink_mask  <= side4_r.blink;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

endmodule

FILE: tb/clock_stopwatch_segment_formatter_core_tb.sv
// ----------------------------------------------------------------------------
// clock_stopwatch_segment_formatter_core_tb
// Self-checking bench for the clock and stopwatch segment formatter. A
// scoreboard predicts the four digit codes and the blink mask of every shown
// beat. Each output beat is compared field by field, in order. Directed beats
// cover the field extremes and every display mode. Random phases then change
// the registers between runs of beats, with random idling on both channels
// and one long output hold that backs up the pipeline.
// ----------------------------------------------------------------------------
module clock_stopwatch_segment_formatter_core_tb;
  import csf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Digit patterns 9 down to 0, so digit d sits at bits [8*d +: 8].
  localparam logic [79:0] DIGIT_SEGS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned RANDOM_BEATS = 2000;

  class segment_scoreboard;
    mode_t       mode;
    bit          edit_minutes;
    out_item_t   expected_codes[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned accepted;

    function new();
      mode = MODE_CLOCK;
      edit_minutes = 1'b0;
      errors = 0;
      checked = 0;
      accepted = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_DISPLAY_MODE) begin
        mode = mode_t'(data[1:0]);
      end else if (idx == REG_EDIT_FIELD) begin
        edit_minutes = data[0];
      end
    endfunction

    function logic [7:0] seg_of(int unsigned d);
      return DIGIT_SEGS[8*d +: 8];
    endfunction

    // Returns 0 when the current mode blanks the display.
    function bit predict_codes(in_item_t it, output out_item_t codes);
      int unsigned left;
      int unsigned right;
      logic [3:0]  blink;
      blink = BLINK_NONE;
      codes = '0;
      case (mode)
        MODE_CLOCK, MODE_SETTING: begin
          left  = 32'(it.hours);
          right = 32'(it.minutes);
          if (mode == MODE_SETTING) begin
            blink = edit_minutes ? BLINK_MINUTES : BLINK_HOURS;
          end
        end
        MODE_STOPWATCH: begin
          left  = (it.elapsed_ms / 60000) % 100;
          right = (it.elapsed_ms / 1000) % 60;
        end
        default: return 1'b0;
      endcase
      codes.segments_d3 = seg_of(left / 10);
      codes.segments_d2 = seg_of(left % 10) | SEG_DP;
      codes.segments_d1 = seg_of(right / 10);
      codes.segments_d0 = seg_of(right % 10);
      codes.blink_mask  = blink;
      return 1'b1;
    endfunction

    function void note_input(in_item_t it);
      out_item_t codes;
      accepted++;
      if (predict_codes(it, codes)) begin
        expected_codes.push_back(codes);
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat, expected none, actual %h", $time, got);
        return;
      end
      want = expected_codes.pop_front();
      checked++;
      check_field("segments_d3", want.segments_d3, got.segments_d3);
      check_field("segments_d2", want.segments_d2, got.segments_d2);
      check_field("segments_d1", want.segments_d1, got.segments_d1);
      check_field("segments_d0", want.segments_d0, got.segments_d0);
      check_field("blink_mask", {4'h0, want.blink_mask}, {4'h0, got.blink_mask});
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  segment_scoreboard sb = new();
  bit          hold_request = 1'b0;
  bit          sender_steady = 1'b0;
  int unsigned settings_used = 0;

  clock_stopwatch_segment_formatter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly back to back, sometimes a short gap, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_item();
    in_item_t    it;
    int unsigned r;
    it.hours   = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    it.minutes = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    r = $urandom_range(0, 3);
    case (r)
      0: it.elapsed_ms = $urandom_range(0, 6100000);
      1: it.elapsed_ms = $urandom_range(0, 4294966) * 1000 + ($urandom_range(0, 1) ? 999 : 0);
      2: it.elapsed_ms = $urandom_range(0, 71582) * 60000 + ($urandom_range(0, 1) ? 59999 : 0);
      default: it.elapsed_ms = $urandom;
    endcase
    return it;
  endfunction

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits carry random junk that the registers must ignore.
  task automatic set_display(mode_t mode, bit edit_minutes);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[1:0] = mode;
    write_cfg(REG_DISPLAY_MODE, data);
    data = $urandom;
    data[0] = edit_minutes;
    write_cfg(REG_EDIT_FIELD, data);
    settings_used++;
  endtask

  // A gap of zero keeps valid high straight into the next beat.
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic send_fields(logic [4:0] h, logic [5:0] m, logic [31:0] ms);
    in_item_t it;
    it.hours = h;
    it.minutes = m;
    it.elapsed_ms = ms;
    send_item(it);
  endtask

  // Blanked beats leave nothing to wait for, so the pipeline gets extra time.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (sb.expected_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int unsigned stall;
    int unsigned steady_left;
    steady_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (steady_left == 0 && $urandom_range(0, 19) == 0) steady_left = 40;
        if (steady_left > 0) begin
          steady_left--;
          stall = 0;
        end else begin
          stall = pick_gap();
        end
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  initial begin : stimulus
    int unsigned shown_beats;
    int unsigned count;
    int unsigned phase;
    mode_t       mode;
    logic [CFG_INDEX_W-1:0] junk_index;
    shown_beats = 0;
    phase = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values give clock mode with no blinking.
    send_fields(5'd0, 6'd0, 32'd0);
    send_fields(5'd23, 6'd59, 32'hFFFF_FFFF);
    send_fields(5'd31, 6'd63, 32'd60000);
    send_fields(5'd10, 6'd9, 32'd999);
    finish_phase();

    set_display(MODE_SETTING, 1'b0);
    send_fields(5'd12, 6'd34, 32'd0);
    send_fields(5'd31, 6'd63, 32'd1);
    finish_phase();
    set_display(MODE_SETTING, 1'b1);
    send_fields(5'd7, 6'd5, 32'd0);
    send_fields(5'd20, 6'd40, 32'd12345);
    finish_phase();

    // Second and minute boundaries, the 99:59 top and the wrap to 00:00.
    set_display(MODE_STOPWATCH, 1'b1);
    send_fields(5'd31, 6'd63, 32'd0);
    send_fields(5'd0, 6'd0, 32'd999);
    send_fields(5'd0, 6'd0, 32'd1000);
    send_fields(5'd0, 6'd0, 32'd59999);
    send_fields(5'd0, 6'd0, 32'd60000);
    send_fields(5'd0, 6'd0, 32'd5999999);
    send_fields(5'd0, 6'd0, 32'd6000000);
    send_fields(5'd0, 6'd0, 32'hFFFF_FFFF);
    finish_phase();

    set_display(MODE_OTHER, 1'b0);
    send_fields(5'd23, 6'd59, 32'hFFFF_FFFF);
    send_fields(5'd0, 6'd0, 32'd0);
    finish_phase();

    // Writes beyond the two registers must leave the mode alone.
    write_cfg(8'd2, 32'd0);
    write_cfg(8'hFF, 32'hFFFF_FFFF);
    send_fields(5'd1, 6'd2, 32'd3);
    finish_phase();

    while (shown_beats < RANDOM_BEATS) begin
      mode = mode_t'($urandom_range(0, 3));
      if (phase < 4) mode = (phase == 3) ? MODE_STOPWATCH : mode_t'(phase % 3);
      set_display(mode, 1'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        junk_index = CFG_INDEX_W'($urandom_range(2, 255));
        write_cfg(junk_index, $urandom);
      end
      sender_steady = ($urandom_range(0, 3) == 0) || (phase == 2);
      if (phase == 2) hold_request = 1'b1;
      count = $urandom_range(50, 200);
      repeat (count) send_item(make_item());
      shown_beats += count;
      sender_steady = 1'b0;
      finish_phase();
      phase++;
    end

    $display("Checked %0d output beats from %0d input beats across %0d register settings.",
             sb.checked, sb.accepted, settings_used);
    $display("Covered clock, setting with both edit fields, stopwatch and blanked modes.");
    if (sb.errors == 0 && sb.expected_codes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/csf_pkg.sv
hdl/csf_seg_pair.sv
hdl/clock_stopwatch_segment_formatter_core.sv
tb/clock_stopwatch_segment_formatter_core_tb.sv
